/* design/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, codes and helpers of the set-associative LRU tag cache.
// ----------------------------------------------------------------------------
package salc_pkg;

  // access kinds
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_STORE  = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_OFF_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS     = 2'd2;

  localparam logic [2:0] SET_BITS_RST = 3'd4;
  localparam logic [5:0] OFF_BITS_RST = 6'd4;
  localparam logic [2:0] WAYS_RST     = 3'd1;

  localparam logic [1:0] RANK_MAX = 2'd3;
  localparam int unsigned CNT_W = 32;

  // per-line replacement state, one lane per way in a set row
  typedef struct packed {
    logic       valid;
    logic [1:0] rank;
  } salc_meta_t;

  // recency update request for one set
  typedef struct packed {
    logic       age_all;
    logic [1:0] old_rank;
  } salc_upd_t;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v, logic en);
    logic [CNT_W-1:0] r;
    r = v;
    if (en && (v != {CNT_W{1'b1}})) begin
      r = v + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

/* design/salc_ram.sv */
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/salc_lru.sv */
// ----------------------------------------------------------------------------
// salc_lru
// Recency update of a set row: the touched way becomes most recent; other
// valid ways in use below old_rank (all if age_all) age by one, saturating.
// ----------------------------------------------------------------------------
module salc_lru #(
  parameter int unsigned MAX_WAYS = 4,
  parameter int unsigned WAY_BITS = 2
) (
  input  salc_pkg::salc_meta_t [MAX_WAYS-1:0] row_i,
  input  logic [WAY_BITS-1:0]                 tgt_way_i,
  input  logic [WAY_BITS-1:0]                 last_way_i,
  input  salc_pkg::salc_upd_t                 upd_i,
  output salc_pkg::salc_meta_t [MAX_WAYS-1:0] row_o
);

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_o[w] = row_i[w];
      if (WAY_BITS'(w) <= last_way_i) begin
        if (WAY_BITS'(w) == tgt_way_i) begin
          row_o[w].valid = 1'b1;
          row_o[w].rank  = '0;
        end else if (row_i[w].valid && (upd_i.age_all || row_i[w].rank < upd_i.old_rank)
                     && row_i[w].rank != salc_pkg::RANK_MAX) begin
          row_o[w].rank = row_i[w].rank + 2'd1;
        end
      end
    end
  end

endmodule

/* design/set_assoc_lru_cache_tag_sim.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_sim
// Tag-only set-associative cache with true LRU replacement and saturating
// hit, miss and eviction counters.
// ----------------------------------------------------------------------------
// After reset the block clears the valid bits and ranks of every set row
// and holds in_stall_o high meanwhile. A request then passes through the
// split, scan, update and done states until its result is loaded: one
// shared tag comparator walks the ways of the set one per cycle, reading
// one tag per cycle from the tag RAM, and stops at the first hit or at
// the last way in use. One request is processed at a time and the next
// one can be taken in the cycle after the result is loaded. A result waiting
// on out_stall_i does not block the next request from being accepted, but
// the result of that next request waits until the output register is free.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_sim #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 4,
  parameter int unsigned ADDR_BITS    = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [ADDR_BITS-1:0]   address_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   was_hit_o,
  output logic                   was_eviction_o,
  output logic                   extra_hit_o,
  output logic [31:0]            hit_total_o,
  output logic [31:0]            miss_total_o,
  output logic [31:0]            eviction_total_o
);

  localparam int unsigned SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned META_W   = MAX_WAYS * $bits(salc_pkg::salc_meta_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SPLIT,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_e;

  // configuration registers
  logic [2:0] set_index_bits_q;
  logic [5:0] block_offset_bits_q;
  logic [2:0] ways_in_use_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_index_bits_q    <= salc_pkg::SET_BITS_RST;
      block_offset_bits_q <= salc_pkg::OFF_BITS_RST;
      ways_in_use_q       <= salc_pkg::WAYS_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        salc_pkg::REG_SET_BITS: set_index_bits_q    <= pwdata[2:0];
        salc_pkg::REG_OFF_BITS: block_offset_bits_q <= pwdata[5:0];
        salc_pkg::REG_WAYS:     ways_in_use_q       <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      salc_pkg::REG_SET_BITS: prdata = {29'd0, set_index_bits_q};
      salc_pkg::REG_OFF_BITS: prdata = {26'd0, block_offset_bits_q};
      salc_pkg::REG_WAYS:     prdata = {29'd0, ways_in_use_q};
      default:                prdata = '0;
    endcase
  end

  // sequencer registers
  state_e                state_q;
  logic [SET_W-1:0]      clr_q;
  logic [1:0]            func_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [SET_W-1:0]      set_q;
  logic [ADDR_BITS-1:0]  tag_q;
  logic [WAY_BITS-1:0]   way_q;
  logic [WAY_BITS-1:0]   last_way_q;
  logic                  hit_q;
  logic                  inv_found_q;
  logic [WAY_BITS-1:0]   inv_way_q;
  logic [WAY_BITS-1:0]   vic_q;
  logic [1:0]            vic_rank_q;
  logic [31:0]           hit_cnt_q;
  logic [31:0]           miss_cnt_q;
  logic [31:0]           evict_cnt_q;
  logic                  out_valid_q;
  logic                  was_hit_q;
  logic                  was_evict_q;
  logic                  extra_hit_q;
  logic [31:0]           hit_tot_q;
  logic [31:0]           miss_tot_q;
  logic [31:0]           evict_tot_q;

  // address split
  logic [3:0]            sbits;
  logic [ADDR_BITS-1:0]  off_shifted;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_d;
  logic [6:0]            tag_shift;
  logic [ADDR_BITS-1:0]  tag_d;
  logic [4:0]            ways_req;
  logic [4:0]            ways_eff;
  logic [WAY_BITS-1:0]   last_way_d;

  always_comb begin
    sbits = ({1'b0, set_index_bits_q} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                          : {1'b0, set_index_bits_q};
    off_shifted = addr_q >> block_offset_bits_q;
    // a full-width shift wraps to zero, so the mask becomes all ones
    set_mask  = (SET_W'(1) << sbits) - SET_W'(1);
    set_d     = off_shifted[SET_W-1:0] & set_mask;
    tag_shift = 7'(block_offset_bits_q) + 7'(sbits);
    tag_d     = addr_q >> tag_shift;
    ways_req  = {2'b00, ways_in_use_q};
    if (ways_req == 5'd0) begin
      ways_eff = 5'd1;
    end else if (ways_req > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = ways_req;
    end
    last_way_d = WAY_BITS'(ways_eff - 5'd1);
  end

  // memories
  salc_pkg::salc_meta_t [MAX_WAYS-1:0] meta_rdata;
  salc_pkg::salc_meta_t [MAX_WAYS-1:0] meta_new;
  logic                  meta_we;
  logic [SET_W-1:0]      meta_waddr;
  logic [META_W-1:0]     meta_wdata;
  logic                  meta_re;
  logic [ADDR_BITS-1:0]  tag_rdata;
  logic                  tag_we;
  logic                  tag_re;
  logic [SET_W+WAY_BITS-1:0] tag_raddr;
  logic [WAY_BITS-1:0]   tgt_way;
  salc_pkg::salc_upd_t   upd;

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = set_q;
    meta_wdata = meta_new;
    meta_re    = (state_q == S_SPLIT);
    tag_re     = 1'b0;
    tag_raddr  = {set_q, way_q + WAY_BITS'(1)};
    tag_we     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
      end
      S_SPLIT: begin
        tag_re    = 1'b1;
        tag_raddr = {set_d, WAY_BITS'(0)};
      end
      S_SCAN: begin
        tag_re = 1'b1;
      end
      S_UPDATE: begin
        meta_we = 1'b1;
        tag_we  = !hit_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (hit_q) begin
      tgt_way = way_q;
    end else if (inv_found_q) begin
      tgt_way = inv_way_q;
    end else begin
      tgt_way = vic_q;
    end
    upd.age_all  = !hit_q;
    upd.old_rank = meta_rdata[way_q].rank;
  end

  salc_ram #(
    .WIDTH (META_W),
    .DEPTH (2 ** SET_W)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (set_d),
    .rdata_o (meta_rdata)
  );

  salc_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (2 ** (SET_W + WAY_BITS))
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i ({set_q, tgt_way}),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  salc_lru #(
    .MAX_WAYS (MAX_WAYS),
    .WAY_BITS (WAY_BITS)
  ) u_lru (
    .row_i      (meta_rdata),
    .tgt_way_i  (tgt_way),
    .last_way_i (last_way_q),
    .upd_i      (upd),
    .row_o      (meta_new)
  );

  // shared tag comparator on the way being walked
  logic       way_valid;
  logic [1:0] way_rank;
  logic       tag_match;
  logic       out_free;

  assign way_valid = meta_rdata[way_q].valid;
  assign way_rank  = meta_rdata[way_q].rank;
  assign tag_match = way_valid && (tag_rdata == tag_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      func_q      <= '0;
      addr_q      <= '0;
      set_q       <= '0;
      tag_q       <= '0;
      way_q       <= '0;
      last_way_q  <= '0;
      hit_q       <= 1'b0;
      inv_found_q <= 1'b0;
      inv_way_q   <= '0;
      vic_q       <= '0;
      vic_rank_q  <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      out_valid_q <= 1'b0;
      was_hit_q   <= 1'b0;
      was_evict_q <= 1'b0;
      extra_hit_q <= 1'b0;
      hit_tot_q   <= '0;
      miss_tot_q  <= '0;
      evict_tot_q <= '0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SET_W'(1);
          if (clr_q == {SET_W{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            addr_q  <= address_i;
            state_q <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          set_q       <= set_d;
          tag_q       <= tag_d;
          last_way_q  <= last_way_d;
          way_q       <= '0;
          hit_q       <= 1'b0;
          inv_found_q <= 1'b0;
          state_q     <= S_SCAN;
        end
        S_SCAN: begin
          // lowest way with the strictly highest rank is the victim
          if (way_q == '0 || way_rank > vic_rank_q) begin
            vic_q      <= way_q;
            vic_rank_q <= way_rank;
          end
          if (!way_valid && !inv_found_q) begin
            inv_found_q <= 1'b1;
            inv_way_q   <= way_q;
          end
          if (tag_match) begin
            hit_q   <= 1'b1;
            state_q <= S_UPDATE;
          end else if (way_q == last_way_q) begin
            state_q <= S_UPDATE;
          end else begin
            way_q <= way_q + WAY_BITS'(1);
          end
        end
        S_UPDATE: begin
          hit_cnt_q <= salc_pkg::sat_inc(salc_pkg::sat_inc(hit_cnt_q, hit_q),
                                         func_q == salc_pkg::FUNC_MODIFY);
          miss_cnt_q  <= salc_pkg::sat_inc(miss_cnt_q, !hit_q);
          evict_cnt_q <= salc_pkg::sat_inc(evict_cnt_q, !hit_q && !inv_found_q);
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            was_hit_q   <= hit_q;
            was_evict_q <= !hit_q && !inv_found_q;
            extra_hit_q <= (func_q == salc_pkg::FUNC_MODIFY);
            hit_tot_q   <= hit_cnt_q;
            miss_tot_q  <= miss_cnt_q;
            evict_tot_q <= evict_cnt_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign was_hit_o        = was_hit_q;
  assign was_eviction_o   = was_evict_q;
  assign extra_hit_o      = extra_hit_q;
  assign hit_total_o      = hit_tot_q;
  assign miss_total_o     = miss_tot_q;
  assign eviction_total_o = evict_tot_q;

  // a request blocks further requests until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // the way walk never passes the last way in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> way_q <= last_way_q)
    else $error("way walk out of range");

  // saturating counters never go back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> hit_cnt_q >= $past(hit_cnt_q) && miss_cnt_q >= $past(miss_cnt_q)
             && evict_cnt_q >= $past(evict_cnt_q))
    else $error("counter decreased");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the set-associative LRU tag cache. A tag and
// recency model of its own predicts hit, eviction and running counters for
// every accepted request. Results are compared field by field in order, under
// random idling on both channels and one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_BITS_CAP  = 6;
  localparam int unsigned WAY_CAP       = 4;
  localparam int unsigned LINE_COUNT    = (1 << SET_BITS_CAP) * WAY_CAP;
  localparam int unsigned AGE_ALL       = 4;
  localparam int unsigned TAG_POOL_SIZE = 6;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS   = 75;
  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;

  typedef struct packed {
    logic        was_hit;
    logic        was_eviction;
    logic        extra_hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } cache_outcome_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i      = '0;
  logic [63:0] address_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        was_hit_o;
  logic        was_eviction_o;
  logic        extra_hit_o;
  logic [31:0] hit_total_o;
  logic [31:0] miss_total_o;
  logic [31:0] eviction_total_o;

  // cache model state
  bit          cached_valid [LINE_COUNT];
  logic [63:0] cached_tag   [LINE_COUNT];
  bit [1:0]    recency_rank [LINE_COUNT];
  bit [31:0]   hit_tally;
  bit [31:0]   miss_tally;
  bit [31:0]   evict_tally;
  logic [2:0]  cfg_set_bits = salc_pkg::SET_BITS_RST;
  logic [5:0]  cfg_off_bits = salc_pkg::OFF_BITS_RST;
  logic [2:0]  cfg_ways     = salc_pkg::WAYS_RST;

  cache_outcome_t expected_outcomes[$];
  logic [63:0]    tag_pool[TAG_POOL_SIZE];
  int unsigned    mismatch_count    = 0;
  int unsigned    stall_hold_cycles = 0;
  bit             no_idle           = 1'b0;

  set_assoc_lru_cache_tag_sim #(
    .MAX_SET_BITS(SET_BITS_CAP),
    .MAX_WAYS    (WAY_CAP),
    .ADDR_BITS   (64)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .was_hit_o       (was_hit_o),
    .was_eviction_o  (was_eviction_o),
    .extra_hit_o     (extra_hit_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o),
    .eviction_total_o(eviction_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [63:0] shift_down(logic [63:0] v, int unsigned n);
    return (n >= 64) ? 64'd0 : (v >> n);
  endfunction

  function automatic bit [31:0] bump_sat(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // make one way most recent; lines ranked below old_rank age by one
  function automatic void age_set(int unsigned base, int unsigned ways,
                                  int unsigned fresh, int unsigned old_rank);
    int unsigned w;
    for (w = 0; w < ways; w++) begin
      if (w != fresh && cached_valid[base+w] && recency_rank[base+w] < old_rank &&
          recency_rank[base+w] < salc_pkg::RANK_MAX) begin
        recency_rank[base+w] = recency_rank[base+w] + 2'd1;
      end
    end
    recency_rank[base+fresh] = '0;
  endfunction

  function automatic cache_outcome_t predict_access(logic [1:0] func, logic [63:0] addr);
    cache_outcome_t o;
    int unsigned    sbits, ways, set_idx, base, w, hit_way, victim;
    logic [63:0]    tag;
    bit             found, placed;
    sbits   = (cfg_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : cfg_set_bits;
    ways    = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_CAP) ? WAY_CAP : cfg_ways);
    set_idx = int'(shift_down(addr, cfg_off_bits) & ((64'd1 << sbits) - 64'd1));
    tag     = shift_down(addr, cfg_off_bits + sbits);
    base    = set_idx * WAY_CAP;
    o       = '0;
    found   = 1'b0;
    placed  = 1'b0;
    hit_way = 0;
    for (w = 0; w < ways; w++) begin
      if (!found && cached_valid[base+w] && cached_tag[base+w] == tag) begin
        found   = 1'b1;
        hit_way = w;
      end
    end
    if (found) begin
      age_set(base, ways, hit_way, recency_rank[base+hit_way]);
      hit_tally = bump_sat(hit_tally);
    end else begin
      miss_tally = bump_sat(miss_tally);
      for (w = 0; w < ways; w++) begin
        if (!placed && !cached_valid[base+w]) begin
          placed               = 1'b1;
          cached_valid[base+w] = 1'b1;
          cached_tag[base+w]   = tag;
          age_set(base, ways, w, AGE_ALL);
        end
      end
      if (!placed) begin
        // ties go to the lowest way
        victim = 0;
        for (w = 1; w < ways; w++) begin
          if (recency_rank[base+w] > recency_rank[base+victim]) victim = w;
        end
        cached_tag[base+victim] = tag;
        age_set(base, ways, victim, AGE_ALL);
        evict_tally    = bump_sat(evict_tally);
        o.was_eviction = 1'b1;
      end
    end
    if (func == salc_pkg::FUNC_MODIFY) begin
      hit_tally   = bump_sat(hit_tally);
      o.extra_hit = 1'b1;
    end
    o.was_hit        = found;
    o.hit_total      = hit_tally;
    o.miss_total     = miss_tally;
    o.eviction_total = evict_tally;
    return o;
  endfunction

  // ------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    cache_outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result with no request pending", 64'd0, 64'd0);
      end else begin
        want = expected_outcomes.pop_front();
        if (was_hit_o !== want.was_hit)
          report_mismatch("was_hit", 64'(was_hit_o), 64'(want.was_hit));
        if (was_eviction_o !== want.was_eviction)
          report_mismatch("was_eviction", 64'(was_eviction_o), 64'(want.was_eviction));
        if (extra_hit_o !== want.extra_hit)
          report_mismatch("extra_hit", 64'(extra_hit_o), 64'(want.extra_hit));
        if (hit_total_o !== want.hit_total)
          report_mismatch("hit_total", 64'(hit_total_o), 64'(want.hit_total));
        if (miss_total_o !== want.miss_total)
          report_mismatch("miss_total", 64'(miss_total_o), 64'(want.miss_total));
        if (eviction_total_o !== want.eviction_total)
          report_mismatch("eviction_total", 64'(eviction_total_o),
                          64'(want.eviction_total));
      end
    end
  end

  // result-side hold-off and random idling
  always @(posedge clk_i) begin : result_stall
    if (stall_hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      stall_hold_cycles--;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < 34);
    end
  end

  // ------------------------------------------------------------- stimulus

  task automatic issue_access(logic [1:0] func, logic [63:0] addr);
    if (!no_idle && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    address_i  <= addr;
    do @(posedge clk_i); while (in_stall_o);
    expected_outcomes.push_back(predict_access(func, addr));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      salc_pkg::REG_SET_BITS: cfg_set_bits = value[2:0];
      salc_pkg::REG_OFF_BITS: cfg_off_bits = value[5:0];
      salc_pkg::REG_WAYS:     cfg_ways     = value[2:0];
      default: ;
    endcase
  endtask

  // upper data bits are random, only the field bits count
  task automatic apply_settings(int unsigned set_bits, int unsigned off_bits,
                                int unsigned ways);
    wait_idle();
    write_reg(salc_pkg::REG_SET_BITS, ($urandom & ~32'h7)  | (set_bits & 32'h7));
    write_reg(salc_pkg::REG_OFF_BITS, ($urandom & ~32'h3F) | (off_bits & 32'h3F));
    write_reg(salc_pkg::REG_WAYS,     ($urandom & ~32'h7)  | (ways & 32'h7));
  endtask

  function automatic void refill_tag_pool();
    int unsigned i;
    tag_pool[0] = '0;
    tag_pool[1] = 64'($urandom_range(1, 15));
    for (i = 2; i < TAG_POOL_SIZE; i++) tag_pool[i] = {$urandom, $urandom};
  endfunction

  function automatic logic [1:0] pick_func();
    if ($urandom_range(0, 99) < 5) return FUNC_UNUSED;
    return 2'($urandom_range(0, 2));
  endfunction

  // mostly a few tags over a few sets so that lines conflict and hit
  function automatic logic [63:0] pick_address();
    logic [63:0] tag, set_sel, low;
    int unsigned sbits;
    if ($urandom_range(0, 99) < 15) return {$urandom, $urandom};
    sbits   = (cfg_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : cfg_set_bits;
    tag     = tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)];
    set_sel = ($urandom_range(0, 99) < 70) ? 64'($urandom_range(0, 1))
                                           : 64'($urandom_range(0, 63));
    set_sel = set_sel & ((64'd1 << sbits) - 64'd1);
    low     = {$urandom, $urandom} & ((64'd1 << cfg_off_bits) - 64'd1);
    return (tag << (cfg_off_bits + sbits)) | (set_sel << cfg_off_bits) | low;
  endfunction

  task automatic run_phase(int unsigned items, bit fresh_tags);
    if (fresh_tags) refill_tag_pool();
    repeat (items) issue_access(pick_func(), pick_address());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_config();
    issue_access(salc_pkg::FUNC_LOAD,   64'h0);
    issue_access(salc_pkg::FUNC_LOAD,   64'h8);
    issue_access(salc_pkg::FUNC_STORE,  64'hFFFF_FFFF_FFFF_FFFF);
    issue_access(salc_pkg::FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFF0);
    issue_access(FUNC_UNUSED,           64'h100);
    issue_access(salc_pkg::FUNC_MODIFY, 64'h0);
  endtask

  // whole address as tag; shrinking the ways leaves stale ranks that tie later
  task automatic test_whole_address_tag();
    apply_settings(0, 0, 4);
    issue_access(salc_pkg::FUNC_LOAD,  64'h0);
    issue_access(salc_pkg::FUNC_LOAD,  64'hFFFF_FFFF_FFFF_FFFF);
    issue_access(salc_pkg::FUNC_LOAD,  64'h8000_0000_0000_0000);
    issue_access(salc_pkg::FUNC_LOAD,  64'h1);
    issue_access(salc_pkg::FUNC_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    apply_settings(0, 0, 2);
    issue_access(salc_pkg::FUNC_LOAD,  64'h2);
    issue_access(salc_pkg::FUNC_LOAD,  64'h3);
    apply_settings(0, 0, 4);
    issue_access(salc_pkg::FUNC_LOAD,  64'h4);
    issue_access(salc_pkg::FUNC_LOAD,  64'h5);
    issue_access(salc_pkg::FUNC_LOAD,  64'h1);
  endtask

  task automatic test_wide_offset_and_way_limits();
    apply_settings(7, 63, 7);
    issue_access(salc_pkg::FUNC_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
    issue_access(salc_pkg::FUNC_LOAD,   64'h0);
    issue_access(salc_pkg::FUNC_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
    apply_settings(0, 40, 0);
    issue_access(salc_pkg::FUNC_STORE,  64'h0000_00FF_FFFF_FFFF);
    issue_access(salc_pkg::FUNC_LOAD,   64'hFFFF_FF00_0000_0000);
  endtask

  task automatic test_random_traffic();
    apply_settings(2, 4, 4);
    run_phase(PHASE_ITEMS, 1'b1);
    apply_settings(6, 0, 4);
    run_phase(PHASE_ITEMS, 1'b1);
    apply_settings(0, 32, 3);
    run_phase(PHASE_ITEMS, 1'b1);
    apply_settings(7, 6, 5);
    run_phase(PHASE_ITEMS, 1'b1);
    // same tags across way count changes, contents must survive
    apply_settings(3, 12, 4);
    run_phase(PHASE_ITEMS, 1'b1);
    apply_settings(3, 12, 2);
    run_phase(PHASE_ITEMS, 1'b0);
    apply_settings(3, 12, 4);
    run_phase(PHASE_ITEMS, 1'b0);
    apply_settings($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 7));
    run_phase(PHASE_ITEMS, 1'b1);
  endtask

  task automatic test_no_idle_stretch();
    apply_settings(1, 5, 2);
    no_idle = 1'b1;
    run_phase(60, 1'b1);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    apply_settings(2, 3, 4);
    stall_hold_cycles = 300;
    run_phase(40, 1'b1);
  endtask

  initial begin
    refill_tag_pool();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_config();
    test_whole_address_tag();
    test_wide_offset_and_way_limits();
    test_random_traffic();
    test_no_idle_stretch();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
